/* hdl/mnee_pkg.sv */
package mnee_pkg;

  localparam int unsigned TIME_W             = 32;
  localparam int unsigned TPB_W              = 16;
  localparam int unsigned PITCH_W            = 8;
  localparam int unsigned VEL_W              = 17;
  localparam int unsigned COUNT_W            = 32;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned MAX_BYTES          = 7;
  localparam int unsigned LEN_W              = $clog2(MAX_BYTES + 1);
  localparam int unsigned PROD_W             = TIME_W + TPB_W;
  localparam int unsigned VLQ_BITS           = 28;
  localparam int unsigned VEL_PROD_W         = VEL_W + 7;
  localparam int unsigned DEF_TIME_FRAC_BITS = 16;

  localparam logic [TPB_W-1:0]   TPB_RESET  = 16'd480;
  localparam logic [BYTE_W-1:0]  STATUS_ON  = 8'h90;
  localparam logic [BYTE_W-1:0]  STATUS_OFF = 8'h80;
  localparam logic [BYTE_W-1:0]  CONT_BIT   = 8'h80;
  localparam logic [VEL_PROD_W-1:0] VEL_SCALE = 24'd127;

  typedef logic [BYTE_W-1:0] byte_t;

  // One encoded event handed to the output buffer, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]                 len;
    logic                             err;
    logic [COUNT_W-1:0]               count;
  } load_t;

endpackage

/* hdl/mnee_if.sv */
interface mnee_in_if;
  logic                          valid;
  logic                          ready;
  logic [mnee_pkg::TIME_W-1:0]   event_time;
  logic                          note_on;
  logic [mnee_pkg::PITCH_W-1:0]  pitch_value;
  logic [mnee_pkg::VEL_W-1:0]    velocity_frac;

  modport source (output valid, event_time, note_on, pitch_value, velocity_frac,
                  input ready);
  modport sink   (input valid, event_time, note_on, pitch_value, velocity_frac,
                  output ready);
endinterface

interface mnee_out_if;
  logic                          valid;
  logic                          ready;
  logic [mnee_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_of_event;
  logic                          error_flag;
  logic [mnee_pkg::COUNT_W-1:0]  notes_counted;

  modport source (output valid, out_byte, last_of_event, error_flag, notes_counted,
                  input ready);
  modport sink   (input valid, out_byte, last_of_event, error_flag, notes_counted,
                  output ready);
endinterface

interface mnee_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mnee_pkg::TPB_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/midi_note_event_encoder.sv */
// An accepted event word passes through the input register and the product register,
// and its first byte is offered once it is loaded into the output buffer, which
// happens when the output buffer is free.
// An event puts 3 to 7 bytes on the byte-wide output, a rejected event one byte; the
// single product stage takes a new event only after the previous one has left it.
// Reset (rst_n, synchronous, active low) clears the time, on/off and count state,
// sets ticks_per_beat to 480 and empties every stage.
module midi_note_event_encoder #(
  parameter int unsigned TIME_FRAC_BITS = mnee_pkg::DEF_TIME_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  mnee_in_if.sink     in_ch,
  mnee_out_if.source  out_ch,
  mnee_cfg_if.sink    cfg_ch
);
  import mnee_pkg::*;

  // Rounding constant: one half tick in the fixed-point product, zero when the
  // time has no fraction bits.
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'((64'(1) << TIME_FRAC_BITS) >> 1);

  // Configuration register; the user writes only while the block is idle, unchecked.
  logic [TPB_W-1:0] tpb_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r <= TPB_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      tpb_r <= cfg_ch.data;
    end
  end

  // Committed event state. It is updated only when a good event is handed to the
  // output buffer, and the product stage never runs while another event sits
  // between it and that commit, so no forwarding is needed.
  logic [TIME_W-1:0]  prev_time_r;
  logic               prev_on_r;
  logic [COUNT_W-1:0] note_count_r;

  // Input register: holds the next event while the current one is worked on
  // or while earlier bytes are still being drained.
  logic                in_valid_r;
  logic [TIME_W-1:0]   in_time_r;
  logic                in_on_r;
  logic [PITCH_W-1:0]  in_pitch_r;
  logic [VEL_W-1:0]    in_vel_r;
  logic                in_fire;
  logic                mul_take;

  // Product stage: the time difference scaled by ticks_per_beat, plus the
  // velocity byte, which needs only a small constant multiply.
  logic                prod_valid_r;
  logic [PROD_W-1:0]   prod_r;
  logic                bwd_r;
  logic                prod_on_r;
  logic [PITCH_W-1:0]  prod_pitch_r;
  byte_t               vel_byte_r;
  logic                prod_take;

  // The event time travels with the product so the committed time is exact.
  logic [TIME_W-1:0]   prod_time_r;

  logic [TIME_W-1:0]     diff;
  logic [VEL_PROD_W-1:0] vel_prod;

  assign mul_take    = in_valid_r && !prod_valid_r;
  assign in_ch.ready = !in_valid_r || mul_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign diff     = in_time_r - prev_time_r;
  assign vel_prod = VEL_PROD_W'(in_vel_r) * VEL_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (mul_take) begin
      in_valid_r <= 1'b0;
    end
    if (in_fire) begin
      in_time_r  <= in_ch.event_time;
      in_on_r    <= in_ch.note_on;
      in_pitch_r <= in_ch.pitch_value;
      in_vel_r   <= in_ch.velocity_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (mul_take) begin
      prod_valid_r <= 1'b1;
    end else if (prod_take) begin
      prod_valid_r <= 1'b0;
    end
    if (mul_take) begin
      prod_r       <= PROD_W'(diff) * PROD_W'(tpb_r);
      bwd_r        <= (in_time_r < prev_time_r);
      prod_on_r    <= in_on_r;
      prod_pitch_r <= in_pitch_r;
      vel_byte_r   <= vel_prod[VEL_PROD_W-1 -: BYTE_W];
      prod_time_r  <= in_time_r;
    end
  end

  // Encode stage: round the product to whole ticks, range check it against the
  // 28-bit limit of a variable-length quantity, and lay out the bytes.
  logic [PROD_W:0]    rounded;
  logic [PROD_W:0]    ticks_full;
  logic [VLQ_BITS-1:0] ticks;
  logic               too_big;
  logic               enc_err;
  logic [COUNT_W-1:0] count_nxt;
  load_t              load;
  logic               can_load;

  assign rounded    = {1'b0, prod_r} + HALF;
  assign ticks_full = rounded >> TIME_FRAC_BITS;
  assign too_big    = |ticks_full[PROD_W:VLQ_BITS];
  assign ticks      = ticks_full[VLQ_BITS-1:0];
  assign enc_err    = bwd_r || too_big;

  // Note-on count saturates at all ones.
  assign count_nxt = (prod_on_r && !(&note_count_r)) ? note_count_r + COUNT_W'(1)
                                                      : note_count_r;

  always_comb begin
    logic [LEN_W-1:0] k;
    k          = '0;
    load.bytes = '0;
    load.err   = enc_err;
    if (enc_err) begin
      // A rejected event yields one zero byte and keeps the old count.
      load.len   = LEN_W'(1);
      load.count = note_count_r;
    end else begin
      // Delta ticks, most significant 7-bit group first; leading zero groups
      // are dropped and every group but the last carries the continuation bit.
      if (|ticks[27:21]) begin
        load.bytes[k] = CONT_BIT | {1'b0, ticks[27:21]};
        k = k + LEN_W'(1);
      end
      if (|ticks[27:14]) begin
        load.bytes[k] = CONT_BIT | {1'b0, ticks[20:14]};
        k = k + LEN_W'(1);
      end
      if (|ticks[27:7]) begin
        load.bytes[k] = CONT_BIT | {1'b0, ticks[13:7]};
        k = k + LEN_W'(1);
      end
      load.bytes[k] = {1'b0, ticks[6:0]};
      k = k + LEN_W'(1);
      // Running status: the status byte appears only when on/off changes.
      if (prod_on_r != prev_on_r) begin
        load.bytes[k] = prod_on_r ? STATUS_ON : STATUS_OFF;
        k = k + LEN_W'(1);
      end
      load.bytes[k] = prod_pitch_r;
      k = k + LEN_W'(1);
      load.bytes[k] = vel_byte_r;
      k = k + LEN_W'(1);
      load.len   = k;
      load.count = count_nxt;
    end
  end

  assign prod_take = prod_valid_r && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r  <= '0;
      prev_on_r    <= 1'b0;
      note_count_r <= '0;
    end else if (prod_take && !enc_err) begin
      prev_time_r  <= prod_time_r;
      prev_on_r    <= prod_on_r;
      note_count_r <= count_nxt;
    end
  end

  mnee_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (prod_valid_r),
    .load       (load),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

  // A rejected event is always a lone, zero, final byte.
  a_err_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error_flag |-> out_ch.last_of_event && out_ch.out_byte == '0)
    else $error("error result is not a lone zero byte");

  // Committed time never moves backward.
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> prev_time_r >= $past(prev_time_r))
    else $error("committed event time moved backward");

  // The note-on count never decreases.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> note_count_r >= $past(note_count_r))
    else $error("note-on count decreased");

  // State changes only when a good event is handed to the output buffer.
  a_commit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(prod_take && !enc_err) |-> $stable(prev_on_r)
      && $stable(prev_time_r))
    else $error("event state changed without a commit");

endmodule

/* hdl/mnee_out_buf.sv */
module mnee_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_valid,
  input  mnee_pkg::load_t load,
  output logic            can_load,
  mnee_out_if.source      out_ch
);
  import mnee_pkg::*;

  logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_r, buf_nxt;
  logic [LEN_W-1:0]                 len_r, len_nxt;
  logic                             err_r, err_nxt;
  logic [COUNT_W-1:0]               count_r, count_nxt;
  logic                             pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (len_r == '0) || (len_r == LEN_W'(1) && pop);

  always_comb begin
    buf_nxt   = buf_r;
    len_nxt   = len_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (load_valid && can_load) begin
      buf_nxt   = load.bytes;
      len_nxt   = load.len;
      err_nxt   = load.err;
      count_nxt = load.count;
    end else if (pop) begin
      // Slide the next byte into the head slot.
      buf_nxt = buf_r >> BYTE_W;
      len_nxt = len_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
    buf_r   <= buf_nxt;
    err_r   <= err_nxt;
    count_r <= count_nxt;
  end

  assign out_ch.valid         = (len_r != '0);
  assign out_ch.out_byte      = buf_r[0];
  assign out_ch.last_of_event = (len_r == LEN_W'(1));
  assign out_ch.error_flag    = err_r;
  assign out_ch.notes_counted = count_r;

endmodule
